FILE: src/cbq_pkg.sv
// shared types, constants and saturation helpers for the cascaded biquad equalizer
// no dependencies; imported by every module of the block
package cbq_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int STATE_BITS   = SAMPLE_BITS + 16;
    localparam int COEF_BITS    = 32;
    localparam int COEF_FRAC    = COEF_BITS - 6;
    localparam int MAX_SECTIONS = 32;
    localparam int SEC_BITS     = $clog2(MAX_SECTIONS);
    localparam int PROD_BITS    = COEF_BITS + STATE_BITS;
    localparam int SHP_BITS     = PROD_BITS - COEF_FRAC;
    localparam int ACC_BITS     = SHP_BITS + 2;
    localparam int CFG_BITS     = 6;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [1:0] OP_AUDIO = 2'd0;
    localparam logic [1:0] OP_COEF  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] SEL_GAIN  = 3'd0;
    localparam logic [2:0] SEL_ZERO0 = 3'd1;
    localparam logic [2:0] SEL_ZERO1 = 3'd2;
    localparam logic [2:0] SEL_POLE0 = 3'd3;
    localparam logic [2:0] SEL_POLE1 = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SECTIONS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEREO   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POWER    = 2'd2;

    // phases of one section step
    localparam logic [2:0] PH_READ  = 3'd0;
    localparam logic [2:0] PH_POLE0 = 3'd1;
    localparam logic [2:0] PH_POLE1 = 3'd2;
    localparam logic [2:0] PH_ZERO0 = 3'd3;
    localparam logic [2:0] PH_ZERO1 = 3'd4;
    localparam logic [2:0] PH_GAIN  = 3'd5;
    localparam logic [2:0] PH_OUT   = 3'd6;

    localparam logic signed [COEF_BITS-1:0] GAIN_UNITY =
        COEF_BITS'(64'sd1 <<< COEF_FRAC);

    typedef logic signed [COEF_BITS-1:0]  coef_word_t;
    typedef logic signed [STATE_BITS-1:0] state_word_t;

    typedef struct packed {
        coef_word_t gain;
        coef_word_t zero0;
        coef_word_t zero1;
        coef_word_t pole0;
        coef_word_t pole1;
    } cbq_coef_t;

    typedef struct packed {
        logic                load;
        logic                clear;
        logic                run;
        logic [2:0]          phase;
        logic [SEC_BITS-1:0] sec;
    } cbq_ctrl_t;

    function automatic state_word_t sat_state(input logic signed [ACC_BITS-1:0] v);
        logic [ACC_BITS-STATE_BITS:0] top;
        state_word_t r;
        top = v[ACC_BITS-1:STATE_BITS-1];
        if ((&top) || !(|top))
            r = v[STATE_BITS-1:0];
        else if (v[ACC_BITS-1])
            r = {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            r = {1'b0, {(STATE_BITS-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input state_word_t v);
        logic [STATE_BITS-SAMPLE_BITS:0] top;
        logic signed [SAMPLE_BITS-1:0] r;
        top = v[STATE_BITS-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
            r = v[SAMPLE_BITS-1:0];
        else if (v[STATE_BITS-1])
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return r;
    endfunction

endpackage

FILE: src/cbq_coef_store.sv
// per-section coefficient memories with reset-to-default valid bits
// depends on cbq_pkg
module cbq_coef_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [cbq_pkg::SEC_BITS-1:0] wr_sec,
    input  logic [2:0]                   wr_sel,
    input  cbq_pkg::coef_word_t          wr_value,
    input  logic                         rd_en,
    input  logic [cbq_pkg::SEC_BITS-1:0] rd_sec,
    output cbq_pkg::cbq_coef_t           coef
);
    import cbq_pkg::*;

    coef_word_t gain_mem  [MAX_SECTIONS];
    coef_word_t zero0_mem [MAX_SECTIONS];
    coef_word_t zero1_mem [MAX_SECTIONS];
    coef_word_t pole0_mem [MAX_SECTIONS];
    coef_word_t pole1_mem [MAX_SECTIONS];

    logic [4:0][MAX_SECTIONS-1:0] valid_reg;
    logic [4:0]                   rd_ok_reg;
    cbq_coef_t                    rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_sel)
                SEL_GAIN:  gain_mem[wr_sec]  <= wr_value;
                SEL_ZERO0: zero0_mem[wr_sec] <= wr_value;
                SEL_ZERO1: zero1_mem[wr_sec] <= wr_value;
                SEL_POLE0: pole0_mem[wr_sec] <= wr_value;
                SEL_POLE1: pole1_mem[wr_sec] <= wr_value;
                default:   ;
            endcase
        end
        if (rd_en)
        begin
            rd_reg.gain  <= gain_mem[rd_sec];
            rd_reg.zero0 <= zero0_mem[rd_sec];
            rd_reg.zero1 <= zero1_mem[rd_sec];
            rd_reg.pole0 <= pole0_mem[rd_sec];
            rd_reg.pole1 <= pole1_mem[rd_sec];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= '0;
        end
        else
        begin
            if (wr_en && wr_sel <= SEL_POLE1)
                valid_reg[wr_sel][wr_sec] <= 1'b1;
            if (rd_en)
            begin
                for (int k = 0; k < 5; k++)
                    rd_ok_reg[k] <= valid_reg[k][rd_sec];
            end
        end
    end

    // entries never written read as their reset value
    always_comb
    begin
        coef.gain  = rd_ok_reg[SEL_GAIN]  ? rd_reg.gain  : GAIN_UNITY;
        coef.zero0 = rd_ok_reg[SEL_ZERO0] ? rd_reg.zero0 : '0;
        coef.zero1 = rd_ok_reg[SEL_ZERO1] ? rd_reg.zero1 : '0;
        coef.pole0 = rd_ok_reg[SEL_POLE0] ? rd_reg.pole0 : '0;
        coef.pole1 = rd_ok_reg[SEL_POLE1] ? rd_reg.pole1 : '0;
    end

endmodule

FILE: src/cbq_lane.sv
// one channel lane: delay memory and a shared multiplier stepping through a section
// depends on cbq_pkg
module cbq_lane (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cbq_pkg::cbq_ctrl_t                     ctrl,
    input  logic                                   enable,
    input  logic signed [cbq_pkg::SAMPLE_BITS-1:0] x_in,
    input  cbq_pkg::cbq_coef_t                     coef,
    output cbq_pkg::state_word_t                   y
);
    import cbq_pkg::*;

    logic [2*STATE_BITS-1:0] delay_mem [MAX_SECTIONS];
    logic [2*STATE_BITS-1:0] rd_reg;
    logic                    rd_ok_reg;
    logic [MAX_SECTIONS-1:0] valid_reg;

    state_word_t                   x_reg, w_reg, s0, s1, mul_b;
    coef_word_t                    mul_a;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [SHP_BITS-1:0]    shp;
    logic signed [ACC_BITS-1:0]    acc_w_reg, acc_y_reg, shp_ext, x_ext, y_sum;
    logic                          step;

    assign step    = ctrl.run && enable;
    assign s0      = rd_ok_reg ? rd_reg[2*STATE_BITS-1:STATE_BITS] : '0;
    assign s1      = rd_ok_reg ? rd_reg[STATE_BITS-1:0] : '0;
    assign shp     = prod_reg[PROD_BITS-1:COEF_FRAC];
    assign shp_ext = {{(ACC_BITS-SHP_BITS){shp[SHP_BITS-1]}}, shp};
    assign x_ext   = {{(ACC_BITS-STATE_BITS){x_reg[STATE_BITS-1]}}, x_reg};
    assign y_sum   = acc_y_reg + shp_ext;
    assign y       = x_reg;

    always_comb
    begin
        case (ctrl.phase)
            PH_POLE0:
            begin
                mul_a = coef.pole0;
                mul_b = s0;
            end
            PH_POLE1:
            begin
                mul_a = coef.pole1;
                mul_b = s1;
            end
            PH_ZERO0:
            begin
                mul_a = coef.zero0;
                mul_b = s0;
            end
            PH_ZERO1:
            begin
                mul_a = coef.zero1;
                mul_b = s1;
            end
            default:
            begin
                mul_a = coef.gain;
                mul_b = w_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (step && ctrl.phase == PH_OUT)
            delay_mem[ctrl.sec] <= {w_reg, s0};
        if (step && ctrl.phase == PH_READ)
            rd_reg <= delay_mem[ctrl.sec];

        prod_reg <= mul_a * mul_b;

        if (ctrl.load)
            x_reg <= {{(STATE_BITS-SAMPLE_BITS){x_in[SAMPLE_BITS-1]}}, x_in};
        else if (step)
        begin
            case (ctrl.phase)
                PH_POLE1: acc_w_reg <= x_ext + shp_ext;
                PH_ZERO0: acc_w_reg <= acc_w_reg + shp_ext;
                PH_ZERO1:
                begin
                    w_reg     <= sat_state(acc_w_reg);
                    acc_y_reg <= shp_ext;
                end
                PH_GAIN:  acc_y_reg <= acc_y_reg + shp_ext;
                PH_OUT:   x_reg     <= sat_state(y_sum);
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
                valid_reg <= '0;
            else if (step && ctrl.phase == PH_OUT)
                valid_reg[ctrl.sec] <= 1'b1;
            if (step && ctrl.phase == PH_READ)
                rd_ok_reg <= valid_reg[ctrl.sec];
        end
    end

endmodule

FILE: src/cascaded_biquad_equalizer.sv
// Cascaded biquad equalizer, stereo 24-bit, up to 32 second-order sections per channel.
// Requests enter on in_valid/in_stall, results leave on out_valid/out_stall, one result
// per request. Registers (section count, stereo, power) are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block is idle, as
// the block itself does not enforce it. An audio request runs through the sections in use
// one after another: each lane has one multiplier that serves the five products of a
// section over seven phases (memory read, five products, output). Both lanes run side
// by side on the same coefficients, and the result stage saturates and merges them.
// Coefficient writes, state clears, unused codes and audio with power off answer the
// cycle after they are taken with zero outputs.
// One request is in the block at a time: in_stall is high from acceptance until the
// result is taken, so a new request can be taken in the cycle in which out_valid drops.
// While out_stall is high the result is held in the output register.
// Reset restores unity gain, zero coefficients and zero delay state through valid bits
// at once; there is no clearing pass and the block is ready right after reset.
// Depends on cbq_pkg, cbq_coef_store and cbq_lane.
module cascaded_biquad_equalizer (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic [1:0]                                  operation,
    input  logic signed [cbq_pkg::SAMPLE_BITS-1:0]      sample_left,
    input  logic signed [cbq_pkg::SAMPLE_BITS-1:0]      sample_right,
    input  logic [cbq_pkg::SEC_BITS-1:0]                section_index,
    input  logic [2:0]                                  coefficient_select,
    input  logic signed [31:0]                          coefficient_value,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic signed [cbq_pkg::SAMPLE_BITS-1:0]      out_left,
    output logic signed [cbq_pkg::SAMPLE_BITS-1:0]      out_right,
    input  logic                                        cfg_write,
    input  logic [cbq_pkg::CFG_IDX_BITS-1:0]            cfg_index,
    input  logic [cbq_pkg::CFG_BITS-1:0]                cfg_data
);
    import cbq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [2:0]          phase_reg, phase_next;
    logic [SEC_BITS-1:0] sec_reg, sec_next, last_sec;
    logic [CFG_BITS-1:0] count_reg;
    logic                stereo_reg, power_reg;
    logic                accept, start;

    logic signed [SAMPLE_BITS-1:0] left_reg, left_next, right_reg, right_next;

    cbq_ctrl_t   ctrl;
    cbq_coef_t   coef;
    state_word_t y_left, y_right;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign start     = accept && operation == OP_AUDIO && power_reg;
    assign out_valid = (state_reg == ST_OUT);
    assign out_left  = left_reg;
    assign out_right = right_reg;

    // zero sections act as one, more than the store holds act as all of them
    always_comb
    begin
        if (count_reg == '0)
            last_sec = '0;
        else if (count_reg > CFG_BITS'(MAX_SECTIONS))
            last_sec = SEC_BITS'(MAX_SECTIONS - 1);
        else
            last_sec = SEC_BITS'(count_reg - 1'b1);
    end

    always_comb
    begin
        ctrl.load  = start;
        ctrl.clear = accept && operation == OP_CLEAR;
        ctrl.run   = (state_reg == ST_RUN);
        ctrl.phase = phase_reg;
        ctrl.sec   = sec_reg;
    end

    cbq_coef_store u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && operation == OP_COEF),
        .wr_sec   (section_index),
        .wr_sel   (coefficient_select),
        .wr_value (coefficient_value),
        .rd_en    (ctrl.run && phase_reg == PH_READ),
        .rd_sec   (sec_reg),
        .coef     (coef)
    );

    cbq_lane u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .enable (1'b1),
        .x_in   (sample_left),
        .coef   (coef),
        .y      (y_left)
    );

    cbq_lane u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .enable (stereo_reg),
        .x_in   (sample_right),
        .coef   (coef),
        .y      (y_right)
    );

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sec_next   = sec_reg;
        left_next  = left_reg;
        right_next = right_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    left_next  = '0;
                    right_next = '0;
                    phase_next = PH_READ;
                    sec_next   = '0;
                    state_next = start ? ST_RUN : ST_OUT;
                end
            end
            ST_RUN:
            begin
                if (phase_reg == PH_OUT)
                begin
                    phase_next = PH_READ;
                    if (sec_reg == last_sec)
                        state_next = ST_FIN;
                    else
                        sec_next = sec_reg + 1'b1;
                end
                else
                    phase_next = phase_reg + 1'b1;
            end
            ST_FIN:
            begin
                // merge the lanes into the result
                left_next  = sat_sample(y_left);
                right_next = stereo_reg ? sat_sample(y_right) : '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_READ;
            sec_reg    <= '0;
            count_reg  <= CFG_BITS'(1);
            stereo_reg <= 1'b1;
            power_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sec_reg   <= sec_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SECTIONS: count_reg  <= cfg_data;
                    CFG_STEREO:   stereo_reg <= cfg_data[0];
                    CFG_POWER:    power_reg  <= cfg_data[0];
                    default:      ;
                endcase
            end
        end
    end

endmodule

FILE: src/cbq_checker.sv
// port-level checks for the cascaded biquad equalizer, bound to the top level
// depends on cbq_pkg and cascaded_biquad_equalizer
module cbq_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic [1:0]                             operation,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [cbq_pkg::SAMPLE_BITS-1:0] out_left,
    input logic signed [cbq_pkg::SAMPLE_BITS-1:0] out_right
);
    import cbq_pkg::*;

    // one request at a time: taking a request closes the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a request was taken");

    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    a_non_audio_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation != OP_AUDIO |=>
            out_valid && out_left == '0 && out_right == '0)
        else $error("non-audio request did not answer with zeros");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_right))
        else $error("stalled result changed");

endmodule

bind cascaded_biquad_equalizer cbq_checker u_cbq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right)
);

FILE: test/tb_cascaded_biquad_equalizer.sv
// self-checking testbench for cascaded_biquad_equalizer: a queue-fed driver, a result
// monitor and a bit-exact predictor of the section chains
// depends on cbq_pkg and the block's RTL only
`timescale 1ns / 100ps

module tb_cascaded_biquad_equalizer;
    import cbq_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 300;
    localparam int     OP_UNUSED   = 3;

    typedef struct {
        logic [1:0]                     op;
        logic signed [SAMPLE_BITS-1:0]  left;
        logic signed [SAMPLE_BITS-1:0]  right;
        logic [SEC_BITS-1:0]            sec;
        logic [2:0]                     sel;
        logic signed [31:0]             value;
    } request_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } frame_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] operation;
    logic signed [SAMPLE_BITS-1:0] sample_left, sample_right, out_left, out_right;
    logic [SEC_BITS-1:0] section_index;
    logic [2:0] coefficient_select;
    logic signed [31:0] coefficient_value;
    logic cfg_write;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    request_t pending_requests[$];
    frame_t   awaited_frames[$];
    request_t current;
    bit       taken;
    bit       quiet;
    bit       hold_go, hold_done;
    int       hold_count;
    int       errors;
    longint   cycles;

    // predictor copy of the block state
    longint gain_q[MAX_SECTIONS];
    longint zero_q[2*MAX_SECTIONS];
    longint pole_q[2*MAX_SECTIONS];
    longint delay_l[2*MAX_SECTIONS];
    longint delay_r[2*MAX_SECTIONS];
    logic [5:0] sections_reg;
    bit stereo_reg, power_reg;

    cascaded_biquad_equalizer DUT (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // floor(a*b / 2^COEF_FRAC), magnitude clamped to 2^61
    function automatic longint scaled_product(longint a, longint b);
        logic [127:0] ma, mb, p, q;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        p = ma * mb;
        q = p >> COEF_FRAC;
        if (q > (128'd1 << 61)) q = 128'd1 << 61;
        else if (neg && p[COEF_FRAC-1:0] != 0) q = q + 1;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint filter_channel(longint x, bit right_ch, int n);
        longint s0, s1, w, y;
        for (int i = 0; i < n; i++)
        begin
            s0 = right_ch ? delay_r[2*i] : delay_l[2*i];
            s1 = right_ch ? delay_r[2*i+1] : delay_l[2*i+1];
            w = clamp_bits(x + scaled_product(pole_q[2*i], s0)
                + scaled_product(pole_q[2*i+1], s1), STATE_BITS);
            y = clamp_bits(scaled_product(gain_q[i], w) + scaled_product(zero_q[2*i], s0)
                + scaled_product(zero_q[2*i+1], s1), STATE_BITS);
            if (right_ch)
            begin
                delay_r[2*i+1] = s0;
                delay_r[2*i] = w;
            end
            else
            begin
                delay_l[2*i+1] = s0;
                delay_l[2*i] = w;
            end
            x = y;
        end
        return clamp_bits(x, SAMPLE_BITS);
    endfunction

    function automatic frame_t predict_frame(request_t rq);
        frame_t f;
        int n;
        f.left = '0;
        f.right = '0;
        if (rq.op == OP_AUDIO && power_reg)
        begin
            n = (sections_reg == 0) ? 1 : (sections_reg > MAX_SECTIONS ? MAX_SECTIONS
                : int'(sections_reg));
            f.left = SAMPLE_BITS'(filter_channel(longint'(rq.left), 0, n));
            if (stereo_reg) f.right = SAMPLE_BITS'(filter_channel(longint'(rq.right), 1, n));
        end
        else if (rq.op == OP_COEF)
        begin
            case (rq.sel)
                SEL_GAIN:  gain_q[rq.sec] = longint'(rq.value);
                SEL_ZERO0: zero_q[2*rq.sec] = longint'(rq.value);
                SEL_ZERO1: zero_q[2*rq.sec+1] = longint'(rq.value);
                SEL_POLE0: pole_q[2*rq.sec] = longint'(rq.value);
                SEL_POLE1: pole_q[2*rq.sec+1] = longint'(rq.value);
                default: ;
            endcase
        end
        else if (rq.op == OP_CLEAR)
        begin
            foreach (delay_l[i])
            begin
                delay_l[i] = 0;
                delay_r[i] = 0;
            end
        end
        return f;
    endfunction

    function automatic logic signed [31:0] pick_coef(logic [2:0] sel);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (sel == SEL_GAIN && r < 6) return GAIN_UNITY + $signed($urandom_range(0, 1 << 24))
            - (1 << 23);
        return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int unsigned r;
        r = $urandom_range(0, 99);
        rq.op = (r < 72) ? OP_AUDIO : (r < 92) ? OP_COEF : (r < 96) ? OP_CLEAR : 2'(OP_UNUSED);
        rq.left = SAMPLE_BITS'($urandom);
        rq.right = SAMPLE_BITS'($urandom);
        rq.sec = (r % 3 == 0) ? SEC_BITS'($urandom) : SEC_BITS'($urandom_range(0, 3));
        rq.sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
            : 3'($urandom_range(0, 4));
        rq.value = pick_coef(rq.sel);
        return rq;
    endfunction

    function automatic request_t make_request(logic [1:0] op, int l, int r, int sec,
                                              int sel, int value);
        request_t rq;
        rq.op = op;
        rq.left = SAMPLE_BITS'(l);
        rq.right = SAMPLE_BITS'(r);
        rq.sec = SEC_BITS'(sec);
        rq.sel = 3'(sel);
        rq.value = value;
        return rq;
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() != 0 || awaited_frames.size() != 0 || in_valid)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SECTIONS: sections_reg = data;
            CFG_STEREO:   stereo_reg = data[0];
            CFG_POWER:    power_reg = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || taken))
        begin
            taken = 0;
            if (pending_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= 36))
            begin
                current = pending_requests.pop_front();
                in_valid <= 1'b1;
                operation <= current.op;
                sample_left <= current.left;
                sample_right <= current.right;
                section_index <= current.sec;
                coefficient_select <= current.sel;
                coefficient_value <= current.value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_count = hold_count + 1;
            if (hold_count >= 400) hold_done = 1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 36);
    end

    // acceptance and result checking
    always @(posedge clk)
    begin
        frame_t exp_f;
        if (rst_n)
        begin
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            if (in_valid && !in_stall)
            begin
                awaited_frames.push_back(predict_frame(current));
                taken = 1;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_frames.size() == 0)
                begin
                    $display("%0t: unexpected result left %0d right %0d", $time,
                             out_left, out_right);
                    errors++;
                end
                else
                begin
                    exp_f = awaited_frames.pop_front();
                    if (out_left !== exp_f.left)
                    begin
                        $display("%0t: out_left expected %0d actual %0d", $time,
                                 exp_f.left, out_left);
                        errors++;
                    end
                    if (out_right !== exp_f.right)
                    begin
                        $display("%0t: out_right expected %0d actual %0d", $time,
                                 exp_f.right, out_right);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int n_sel;
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        operation = '0;
        sample_left = '0;
        sample_right = '0;
        section_index = '0;
        coefficient_select = '0;
        coefficient_value = '0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        taken = 0;
        quiet = 0;
        hold_go = 0;
        hold_done = 0;
        hold_count = 0;
        errors = 0;
        cycles = 0;
        foreach (gain_q[i]) gain_q[i] = longint'(GAIN_UNITY);
        foreach (zero_q[i])
        begin
            zero_q[i] = 0;
            pole_q[i] = 0;
            delay_l[i] = 0;
            delay_r[i] = 0;
        end
        sections_reg = 1;
        stereo_reg = 1;
        power_reg = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes of samples and coefficients, every select, odd codes
        pending_requests.push_back(make_request(OP_AUDIO, 8388607, -8388608, 0, 0, 0));
        pending_requests.push_back(make_request(OP_AUDIO, -8388608, 8388607, 0, 0, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_GAIN, 32'h7fffffff));
        pending_requests.push_back(make_request(OP_AUDIO, 8388607, 1, 0, 0, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_GAIN, 32'h80000000));
        pending_requests.push_back(make_request(OP_AUDIO, 8388607, -1, 0, 0, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_GAIN, GAIN_UNITY));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_POLE0, 32'h7fffffff));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_POLE1, 32'h80000000));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_ZERO0, 32'h80000000));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_ZERO1, 32'h7fffffff));
        pending_requests.push_back(make_request(OP_AUDIO, 8388607, -8388608, 0, 0, 0));
        pending_requests.push_back(make_request(OP_AUDIO, 12345, -54321, 0, 0, 0));
        pending_requests.push_back(make_request(OP_AUDIO, -8388608, 8388607, 0, 0, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 31, SEL_POLE0, 32'h01000000));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, 5, 32'h12345678));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, 7, 32'h7fffffff));
        pending_requests.push_back(make_request(2'(OP_UNUSED), 100, 100, 3, 2, 5));
        pending_requests.push_back(make_request(OP_CLEAR, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_AUDIO, 4096, -4096, 0, 0, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_POLE0, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_POLE1, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_ZERO0, 0));
        pending_requests.push_back(make_request(OP_COEF, 0, 0, 0, SEL_ZERO1, 0));

        for (int ph = 0; ph < 12; ph++)
        begin
            // sender pauses here until every result is back
            wait_drained();
            quiet = (ph == 4);
            case (ph % 6)
                0: n_sel = 0;
                1: n_sel = MAX_SECTIONS;
                2: n_sel = 63;
                default: n_sel = $urandom_range(1, 4);
            endcase
            write_register(CFG_SECTIONS, CFG_BITS'(n_sel));
            write_register(CFG_STEREO, CFG_BITS'((ph % 3 == 2) ? 0 : 1));
            write_register(CFG_POWER, CFG_BITS'((ph == 5 || ph == 9) ? 0 : 1));
            if (ph == 7) hold_go = 1;
            for (int k = 0; k < 102; k++)
                pending_requests.push_back(random_request());
        end
        wait_drained();
        write_register(CFG_SECTIONS, CFG_BITS'(1));
        write_register(CFG_STEREO, CFG_BITS'(1));
        write_register(CFG_POWER, CFG_BITS'(1));
        for (int k = 0; k < 20; k++)
            pending_requests.push_back(random_request());
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && awaited_frames.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
